// ===== rtl/core/sha1_pkg.sv =====
package sha1_pkg;

  typedef logic [31:0] word_t;
  typedef word_t [4:0] chain_t;   // index 0 holds h0

  localparam word_t H0 = 32'h67452301;
  localparam word_t H1 = 32'hEFCDAB89;
  localparam word_t H2 = 32'h98BADCFE;
  localparam word_t H3 = 32'h10325476;
  localparam word_t H4 = 32'hC3D2E1F0;
  localparam chain_t H_INIT = {H4, H3, H2, H1, H0};

  localparam word_t K0 = 32'h5A827999;
  localparam word_t K1 = 32'h6ED9EBA1;
  localparam word_t K2 = 32'h8F1BBCDC;
  localparam word_t K3 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam int unsigned SHA1_QUEUE_DEPTH = 4;
  localparam logic [6:0] LAST_ROUND = 7'd79;

  // item kinds after classification; bare idle items never enter the queue
  typedef enum logic [1:0] {
    OP_BYTE,
    OP_END,
    OP_BYTE_END
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
  } q_item_t;

  typedef enum logic [2:0] {
    ST_RUN,
    ST_MARK,
    ST_ZERO,
    ST_LEN,
    ST_DRAIN,
    ST_EMIT
  } back_state_t;

  typedef struct packed {
    logic start;
    logic init;
  } comp_ctl_t;

  function automatic word_t rotl(input word_t x, input int unsigned n);
    rotl = (x << n) | (x >> (32 - n));
  endfunction

  function automatic word_t round_k(input logic [6:0] rnd);
    if (rnd < 7'd20)      round_k = K0;
    else if (rnd < 7'd40) round_k = K1;
    else if (rnd < 7'd60) round_k = K2;
    else                  round_k = K3;
  endfunction

  function automatic word_t round_f(input logic [6:0] rnd, input word_t b,
                                    input word_t c, input word_t d);
    if (rnd < 7'd20)      round_f = (b & c) | (~b & d);
    else if (rnd < 7'd40) round_f = b ^ c ^ d;
    else if (rnd < 7'd60) round_f = (b & c) | (b & d) | (c & d);
    else                  round_f = b ^ c ^ d;
  endfunction

endpackage

// ===== rtl/core/sha1_ifs.sv =====
interface sha1_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       message_end;

  modport source (output valid, data_byte, byte_present, message_end, input ready);
  modport sink   (input valid, data_byte, byte_present, message_end, output ready);
endinterface

interface sha1_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic        digest_last;

  modport source (output valid, digest_word, digest_last, input ready);
  modport sink   (input valid, digest_word, digest_last, output ready);
endinterface

// ===== rtl/core/sha1_front.sv =====
module sha1_front import sha1_pkg::*; (
  sha1_in_if.sink  in_ch,
  input  logic     q_full,
  output logic     q_push,
  output q_item_t  q_item
);

  always_comb begin
    in_ch.ready = !q_full;
    q_item.data = in_ch.data_byte;
    q_item.op   = OP_BYTE;
    q_push      = 1'b0;
    if (in_ch.byte_present && in_ch.message_end) begin
      q_item.op = OP_BYTE_END;
    end else if (in_ch.message_end) begin
      q_item.op = OP_END;
    end
    // idle transactions are taken and dropped
    if (in_ch.valid && !q_full && (in_ch.byte_present || in_ch.message_end)) begin
      q_push = 1'b1;
    end
  end

endmodule

// ===== rtl/core/sha1_fifo.sv =====
module sha1_fifo import sha1_pkg::*; #(
  parameter int unsigned DEPTH = SHA1_QUEUE_DEPTH
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  q_item_t push_item,
  input  logic    pop,
  output q_item_t pop_item,
  output logic    not_empty,
  output logic    full
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  q_item_t         q_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   cnt_r;
  logic            do_push, do_pop;

  assign full      = (cnt_r == CW'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_item  = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== rtl/core/sha1_compress.sv =====
module sha1_compress import sha1_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  comp_ctl_t    ctl,
  input  logic [511:0] block,
  output logic         busy,
  output chain_t       chain
);

  logic        busy_r, fin_r;
  logic [6:0]  rnd_r;
  word_t       a_r, b_r, c_r, d_r, e_r;
  word_t       w_r [16];
  chain_t      h_r;
  word_t       tmp, w_new;
  logic        load;

  assign busy  = busy_r;
  assign chain = h_r;
  assign load  = ctl.start && !busy_r;

  assign tmp   = rotl(a_r, 5) + round_f(rnd_r, b_r, c_r, d_r) + e_r
               + round_k(rnd_r) + w_r[0];
  assign w_new = rotl(w_r[13] ^ w_r[8] ^ w_r[2] ^ w_r[0], 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      rnd_r  <= '0;
      h_r    <= H_INIT;
    end else begin
      if (ctl.init) begin
        h_r <= H_INIT;
      end
      if (load) begin
        busy_r <= 1'b1;
        rnd_r  <= '0;
      end else if (busy_r && !fin_r) begin
        rnd_r <= rnd_r + 7'd1;
        if (rnd_r == LAST_ROUND) begin
          fin_r <= 1'b1;
        end
      end else if (fin_r) begin
        h_r[0] <= h_r[0] + a_r;
        h_r[1] <= h_r[1] + b_r;
        h_r[2] <= h_r[2] + c_r;
        h_r[3] <= h_r[3] + d_r;
        h_r[4] <= h_r[4] + e_r;
        fin_r  <= 1'b0;
        busy_r <= 1'b0;
      end
    end
  end

  // working variables and message schedule window, w_r[0] is the current word
  always_ff @(posedge clk) begin
    if (load) begin
      a_r <= h_r[0];
      b_r <= h_r[1];
      c_r <= h_r[2];
      d_r <= h_r[3];
      e_r <= h_r[4];
      for (int i = 0; i < 16; i++) begin
        w_r[i] <= block[511 - 32*i -: 32];
      end
    end else if (busy_r && !fin_r) begin
      a_r <= tmp;
      b_r <= a_r;
      c_r <= rotl(b_r, 30);
      d_r <= c_r;
      e_r <= d_r;
      for (int i = 0; i < 15; i++) begin
        w_r[i] <= w_r[i+1];
      end
      w_r[15] <= w_new;
    end
  end

endmodule

// ===== rtl/core/sha1_back.sv =====
module sha1_back import sha1_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  q_item_t       q_item,
  output logic          q_pop,
  input  logic          comp_busy,
  input  chain_t        chain,
  output comp_ctl_t     comp_ctl,
  output logic [511:0]  block,
  sha1_out_if.source    out_ch
);

  back_state_t  state_r, state_nxt;
  logic [511:0] blk_r;
  logic [5:0]   fill_r;
  logic         full_r;
  logic [63:0]  bits_r;
  logic [2:0]   len_idx_r, len_idx_nxt;
  logic [2:0]   emit_idx_r, emit_idx_nxt;
  logic         push_ok, push, count_bits, last_out;
  logic [7:0]   push_data, len_byte;

  assign block    = blk_r;
  assign push_ok  = !full_r;
  assign len_byte = bits_r[{3'd7 - len_idx_r, 3'b000} +: 8];
  assign last_out = out_ch.valid && out_ch.ready && (emit_idx_r == 3'd4);

  always_comb begin
    state_nxt      = state_r;
    len_idx_nxt    = len_idx_r;
    emit_idx_nxt   = emit_idx_r;
    q_pop          = 1'b0;
    push           = 1'b0;
    push_data      = q_item.data;
    count_bits     = 1'b0;
    comp_ctl.start = full_r && !comp_busy;
    comp_ctl.init  = 1'b0;
    out_ch.valid   = 1'b0;
    unique case (state_r)
      ST_RUN: begin
        if (q_valid && push_ok) begin
          q_pop = 1'b1;
          unique case (q_item.op)
            OP_BYTE: begin
              push       = 1'b1;
              count_bits = 1'b1;
            end
            OP_END: begin
              state_nxt = ST_MARK;
            end
            OP_BYTE_END: begin
              push       = 1'b1;
              count_bits = 1'b1;
              state_nxt  = ST_MARK;
            end
            default: ;
          endcase
        end
      end
      ST_MARK: begin
        push_data = PAD_MARK;
        if (push_ok) begin
          push      = 1'b1;
          state_nxt = ST_ZERO;
        end
      end
      ST_ZERO: begin
        push_data = 8'h00;
        if (push_ok) begin
          if (fill_r == 6'd56) begin
            state_nxt   = ST_LEN;
            len_idx_nxt = '0;
          end else begin
            push = 1'b1;
          end
        end
      end
      ST_LEN: begin
        push_data = len_byte;
        if (push_ok) begin
          push        = 1'b1;
          len_idx_nxt = len_idx_r + 3'd1;
          if (len_idx_r == 3'd7) begin
            state_nxt = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (!full_r && !comp_busy) begin
          state_nxt    = ST_EMIT;
          emit_idx_nxt = '0;
        end
      end
      ST_EMIT: begin
        out_ch.valid = 1'b1;
        if (out_ch.ready) begin
          emit_idx_nxt = emit_idx_r + 3'd1;
          if (emit_idx_r == 3'd4) begin
            comp_ctl.init = 1'b1;
            state_nxt     = ST_RUN;
          end
        end
      end
      default: state_nxt = ST_RUN;
    endcase
  end

  assign out_ch.digest_word = chain[emit_idx_r];
  assign out_ch.digest_last = (emit_idx_r == 3'd4);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_RUN;
    end else begin
      state_r    <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r     <= '0;
      full_r     <= 1'b0;
      bits_r     <= '0;
      len_idx_r  <= '0;
      emit_idx_r <= '0;
    end else begin
      len_idx_r  <= len_idx_nxt;
      emit_idx_r <= emit_idx_nxt;
      if (push) begin
        fill_r <= fill_r + 6'd1;
        if (fill_r == 6'd63) begin
          full_r <= 1'b1;
        end
      end else if (comp_ctl.start) begin
        full_r <= 1'b0;
      end
      if (last_out) begin
        bits_r <= '0;
      end else if (count_bits) begin
        bits_r <= bits_r + 64'd8;
      end
    end
  end

  // block assembly: first byte of a block ends up in the top byte lane
  always_ff @(posedge clk) begin
    if (push) begin
      blk_r <= {blk_r[503:0], push_data};
    end
  end

endmodule

// ===== rtl/core/sha1_message_digest.sv =====
// Channel  | Dir | Payload                                   | Transaction
// ---------+-----+-------------------------------------------+-----------------------------
// in_ch    | in  | data_byte[7:0], byte_present, message_end | one byte and/or end marker
// out_ch   | out | digest_word[31:0], digest_last            | one digest word, h0 first
//
// Flow: the back end takes one byte per cycle unless a full block waits for the round
//   unit, which compresses a block in order (load, 80 rounds, one chaining add),
//   overlapped with filling the next block, so the round unit paces a long message.
//   A message end appends the pad bytes (up to 72: the 0x80 mark, the zero fill and
//   the 64-bit bit length), then one or two block compressions, then five output
//   transactions.
// Reset: synchronous; chaining words load h0..h4, byte and bit counters clear.
// Stalls: the item queue (QUEUE_DEPTH items) lets in_ch keep taking input, until it
//   fills, while the back end compresses, pads or waits on a stalled out_ch.
module sha1_message_digest import sha1_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = SHA1_QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  sha1_in_if.sink    in_ch,
  sha1_out_if.source out_ch
);

  logic         q_push, q_pop, q_valid, q_full;
  q_item_t      q_in_item, q_out_item;
  comp_ctl_t    comp_ctl;
  logic         comp_busy;
  chain_t       chain;
  logic [511:0] block;

  // front end: handshake and classification of each input transaction
  sha1_front u_front (
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_item (q_in_item)
  );

  sha1_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in_item),
    .pop       (q_pop),
    .pop_item  (q_out_item),
    .not_empty (q_valid),
    .full      (q_full)
  );

  // back end: block assembly, padding, length append and digest output
  sha1_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_out_item),
    .q_pop     (q_pop),
    .comp_busy (comp_busy),
    .chain     (chain),
    .comp_ctl  (comp_ctl),
    .block     (block),
    .out_ch    (out_ch)
  );

  // round unit: one SHA-1 round per cycle, owns the chaining words
  sha1_compress u_compress (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (comp_ctl),
    .block (block),
    .busy  (comp_busy),
    .chain (chain)
  );

endmodule

// ===== rtl/core/sha1_checker.sv =====
module sha1_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_word,
  input logic        out_last
);

  logic [2:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (out_valid && out_ready) begin
      cnt_r <= out_last ? 3'd0 : cnt_r + 3'd1;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out valid dropped while stalled");

  a_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_word) && $stable(out_last))
    else $error("out payload changed while stalled");

  a_fifth: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == (cnt_r == 3'd4)))
    else $error("digest_last not on fifth word");

  a_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last |=> !out_valid)
    else $error("digest words right after a finished digest");

endmodule

bind sha1_message_digest sha1_checker u_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_word  (out_ch.digest_word),
  .out_last  (out_ch.digest_last)
);
